/* src/cid_pkg.sv */
// Shared types and constants for the cutter implicit distance pipeline.
// No dependencies.
`default_nettype none
package cid_pkg;

    localparam logic [1:0] SHAPE_FLAT = 2'd0;
    localparam logic [1:0] SHAPE_BALL = 2'd1;
    localparam logic [1:0] SHAPE_BULL = 2'd2;

    localparam logic [2:0] REG_SHAPE  = 3'd0;
    localparam logic [2:0] REG_RADIUS = 3'd1;
    localparam logic [2:0] REG_MAJOR  = 3'd2;
    localparam logic [2:0] REG_MINOR  = 3'd3;
    localparam logic [2:0] REG_LENGTH = 3'd4;
    localparam logic [2:0] REG_POS_X  = 3'd5;
    localparam logic [2:0] REG_POS_Y  = 3'd6;
    localparam logic [2:0] REG_POS_Z  = 3'd7;

    localparam int SQ_STAGES = 16;  // two root bits per stage
    localparam int LATENCY   = 26;  // 3 front + 4 branch + 16 root + 3 ring

    typedef struct packed {
        logic [1:0]         shape;
        logic [14:0]        radius;
        logic [14:0]        length;
        logic [14:0]        tz_off;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [29:0]        rr;
        logic [29:0]        r1sq;
        logic [29:0]        r2sq;
        logic [31:0]        r12sq;
        logic [31:0]        kq;     // 4 * r1^2
    } cid_cfg_t;

    typedef struct packed {
        logic [33:0]        s;
        logic signed [17:0] tz;
        logic [33:0]        tzz;
    } cid_geom_t;

    typedef struct packed {
        logic signed [63:0] val;
        logic               ring;
        logic [33:0]        tzz;
    } cid_carry_t;

    function automatic logic signed [63:0] max64(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage
`default_nettype wire

/* src/cid_front.sv */
// Front stages: offsets, squares and planar radius squared (three stages).
// Depends on cid_pkg.
`default_nettype none
module cid_front (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    ce,
    input  wire logic                    in_valid,
    input  wire logic signed [15:0]      px,
    input  wire logic signed [15:0]      py,
    input  wire logic signed [15:0]      pz,
    input  wire cid_pkg::cid_cfg_t       cfg,
    output logic                         out_valid,
    output cid_pkg::cid_geom_t           geom
);
    logic               v1_reg, v2_reg, v3_reg;
    logic signed [16:0] tx_reg, ty_reg;
    logic signed [17:0] tz1_reg, tz2_reg, tz3_reg;
    logic [33:0]        xx_reg, yy_reg, zz2_reg, zz3_reg, s_reg;
    logic signed [16:0] tx_next, ty_next;
    logic signed [17:0] tz_next;
    logic signed [33:0] xx_p, yy_p;
    logic signed [35:0] zz_p;

    assign tx_next = 17'(px) - 17'(cfg.pos_x);
    assign ty_next = 17'(py) - 17'(cfg.pos_y);
    assign tz_next = 18'(pz) - 18'(cfg.pos_z) - $signed({3'b000, cfg.tz_off});
    assign xx_p = tx_reg * tx_reg;
    assign yy_p = ty_reg * ty_reg;
    assign zz_p = tz1_reg * tz1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            tx_reg  <= tx_next;
            ty_reg  <= ty_next;
            tz1_reg <= tz_next;
            xx_reg  <= xx_p[33:0];
            yy_reg  <= yy_p[33:0];
            zz2_reg <= zz_p[33:0];
            tz2_reg <= tz1_reg;
            s_reg   <= xx_reg + yy_reg;
            zz3_reg <= zz2_reg;
            tz3_reg <= tz2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign geom.s    = s_reg;
    assign geom.tz   = tz3_reg;
    assign geom.tzz  = zz3_reg;
endmodule
`default_nettype wire

/* src/cid_branch.sv */
// Branch stages: shape selection, linear and quadratic branches and the
// split quartic toroid term with saturation (four stages). Depends on cid_pkg.
`default_nettype none
module cid_branch (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                ce,
    input  wire logic                in_valid,
    input  wire cid_pkg::cid_geom_t  geom,
    input  wire cid_pkg::cid_cfg_t   cfg,
    output logic                     out_valid,
    output logic [33:0]              out_s,
    output cid_pkg::cid_carry_t      carry
);
    logic               v4_reg, v5_reg, v6_reg, v7_reg;
    logic signed [63:0] lin4_reg, lin5_reg, lin6_reg;
    logic               ring4_reg, ring5_reg, ring6_reg;
    logic               quart4_reg, quart5_reg, quart6_reg;
    logic [35:0]        amag_reg;
    logic [33:0]        s4_reg, s5_reg, s6_reg, zz4_reg, zz5_reg, zz6_reg;
    logic [35:0]        phh_reg, phl_reg, pll_reg;
    logic [48:0]        pyl_reg, pyh_reg;
    logic [71:0]        x_reg;
    logic [65:0]        y_reg;
    cid_pkg::cid_carry_t carry_reg;
    logic [33:0]        s7_reg;

    logic signed [63:0] tz64, s64, zz64, l64, rr64, lin_next, a64, h64, q_val;
    logic               ring_next, quart_next;
    logic [35:0]        amag_next;
    logic signed [73:0] diff;

    always_comb begin
        tz64 = {{46{geom.tz[17]}}, geom.tz};
        s64  = $signed({30'd0, geom.s});
        zz64 = $signed({30'd0, geom.tzz});
        l64  = $signed({49'd0, cfg.length});
        rr64 = $signed({34'd0, cfg.rr});
        h64  = (tz64 <<< 1) - l64;
        if (h64 < 0) begin
            h64 = -h64;
        end
        a64 = s64 + zz64 + $signed({34'd0, cfg.r1sq}) - $signed({34'd0, cfg.r2sq});
        amag_next  = (a64 < 0) ? 36'(-a64) : 36'(a64);
        ring_next  = 1'b0;
        quart_next = 1'b0;
        case (cfg.shape)
            cid_pkg::SHAPE_BALL: begin
                if (tz64 < 0) begin
                    lin_next = (s64 + zz64 - rr64) <<< 16;
                end else begin
                    lin_next = cid_pkg::max64((tz64 - l64) <<< 24, (s64 - rr64) <<< 16);
                end
            end
            cid_pkg::SHAPE_BULL: begin
                if (tz64 >= 0) begin
                    lin_next = cid_pkg::max64((tz64 - l64) <<< 24,
                        (s64 - $signed({32'd0, cfg.r12sq})) <<< 16);
                end else if (geom.s <= 34'(cfg.r1sq)) begin
                    lin_next = cid_pkg::max64((zz64 - $signed({34'd0, cfg.r2sq})) <<< 16,
                        (s64 - $signed({34'd0, cfg.r1sq})) <<< 16);
                end else begin
                    lin_next   = '0;
                    quart_next = 1'b1;
                end
            end
            default: begin
                if (tz64 >= 0) begin
                    lin_next = cid_pkg::max64((h64 - l64) <<< 23, (s64 - rr64) <<< 16);
                end else if (geom.s < 34'(cfg.rr)) begin
                    lin_next = (-tz64) <<< 24;
                end else begin
                    lin_next  = '0;
                    ring_next = 1'b1;
                end
            end
        endcase
    end

    // signed clamp of x - y to the 64-bit range
    always_comb begin
        diff = $signed({2'b00, x_reg}) - $signed({8'd0, y_reg});
        if (diff > $signed(74'h0_7FFF_FFFF_FFFF_FFFF)) begin
            q_val = 64'sh7FFF_FFFF_FFFF_FFFF;
        end else if (diff < -$signed(74'h0_8000_0000_0000_0000)) begin
            q_val = $signed(64'h8000_0000_0000_0000);
        end else begin
            q_val = diff[63:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (ce) begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            lin4_reg   <= lin_next;
            ring4_reg  <= ring_next;
            quart4_reg <= quart_next;
            amag_reg   <= amag_next;
            s4_reg     <= geom.s;
            zz4_reg    <= geom.tzz;
            // partial products
            phh_reg    <= amag_reg[35:18] * amag_reg[35:18];
            phl_reg    <= amag_reg[35:18] * amag_reg[17:0];
            pll_reg    <= amag_reg[17:0] * amag_reg[17:0];
            pyl_reg    <= cfg.kq * s4_reg[16:0];
            pyh_reg    <= cfg.kq * s4_reg[33:17];
            lin5_reg   <= lin4_reg;
            ring5_reg  <= ring4_reg;
            quart5_reg <= quart4_reg;
            s5_reg     <= s4_reg;
            zz5_reg    <= zz4_reg;
            // sums
            x_reg      <= ({phh_reg, 36'd0}) + 72'({phl_reg, 19'd0}) + 72'(pll_reg);
            y_reg      <= 66'({pyh_reg, 17'd0}) + 66'(pyl_reg);
            lin6_reg   <= lin5_reg;
            ring6_reg  <= ring5_reg;
            quart6_reg <= quart5_reg;
            s6_reg     <= s5_reg;
            zz6_reg    <= zz5_reg;
            // compare, clamp, select
            carry_reg.val  <= quart6_reg ? q_val : lin6_reg;
            carry_reg.ring <= ring6_reg;
            carry_reg.tzz  <= zz6_reg;
            s7_reg         <= s6_reg;
        end
    end

    assign out_valid = v7_reg;
    assign out_s     = s7_reg;
    assign carry     = carry_reg;
endmodule
`default_nettype wire

/* src/cid_sqrt.sv */
// Pipelined floor square root of s * 2^30, two root bits per stage.
// Depends on cid_pkg.
`default_nettype none
module cid_sqrt (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 ce,
    input  wire logic                 in_valid,
    input  wire logic [33:0]          s,
    input  wire cid_pkg::cid_carry_t  in_carry,
    output logic                      out_valid,
    output logic [31:0]               root,
    output cid_pkg::cid_carry_t       out_carry
);
    localparam int N = cid_pkg::SQ_STAGES;

    logic                v_reg   [1:N];
    logic [33:0]         rem_reg [1:N];
    logic [31:0]         q_reg   [1:N];
    logic [33:0]         s_reg   [1:N];
    cid_pkg::cid_carry_t c_reg   [1:N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [33:0] rem_in, s_in, rem_a, rem_b;
        logic [31:0] q_in, q_a, q_b;
        logic [1:0]  pair_a, pair_b;
        logic [35:0] ta, tb;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign q_in   = '0;
            assign s_in   = s;
        end else begin : g_rest
            assign rem_in = rem_reg[k];
            assign q_in   = q_reg[k];
            assign s_in   = s_reg[k];
        end

        // radicand bits 30 and up come from s, the rest are zero
        if (2 * k < 17) begin : g_pa
            assign pair_a = s_in[33 - 4 * k -: 2];
        end else begin : g_za
            assign pair_a = 2'b00;
        end
        if (2 * k + 1 < 17) begin : g_pb
            assign pair_b = s_in[31 - 4 * k -: 2];
        end else begin : g_zb
            assign pair_b = 2'b00;
        end

        always_comb begin
            ta = {rem_in, pair_a};
            if (ta >= {2'b00, q_in, 2'b01}) begin
                rem_a = 34'(ta - {2'b00, q_in, 2'b01});
                q_a   = {q_in[30:0], 1'b1};
            end else begin
                rem_a = ta[33:0];
                q_a   = {q_in[30:0], 1'b0};
            end
            tb = {rem_a, pair_b};
            if (tb >= {2'b00, q_a, 2'b01}) begin
                rem_b = 34'(tb - {2'b00, q_a, 2'b01});
                q_b   = {q_a[30:0], 1'b1};
            end else begin
                rem_b = tb[33:0];
                q_b   = {q_a[30:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k + 1] <= 1'b0;
            end else if (ce) begin
                v_reg[k + 1] <= (k == 0) ? in_valid : v_reg[(k == 0) ? 1 : k];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[k + 1] <= rem_b;
                q_reg[k + 1]   <= q_b;
                s_reg[k + 1]   <= s_in;
                c_reg[k + 1]   <= (k == 0) ? in_carry : c_reg[(k == 0) ? 1 : k];
            end
        end
    end

    assign out_valid = v_reg[N];
    assign root      = q_reg[N];
    assign out_carry = c_reg[N];
endmodule
`default_nettype wire

/* src/cid_ring.sv */
// Ring stages: squared distance to the bottom ring and output register
// (three stages). Depends on cid_pkg.
`default_nettype none
module cid_ring (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 ce,
    input  wire logic                 in_valid,
    input  wire logic [31:0]          root,
    input  wire cid_pkg::cid_carry_t  in_carry,
    input  wire logic [14:0]          radius,
    output logic                      out_valid,
    output logic [63:0]               result
);
    logic                v1_reg, v2_reg, v3_reg;
    logic [31:0]         d_reg;
    logic [63:0]         dd_reg, res_reg;
    cid_pkg::cid_carry_t c1_reg, c2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            d_reg   <= root - {2'b00, radius, 15'd0};
            c1_reg  <= in_carry;
            dd_reg  <= d_reg * d_reg;
            c2_reg  <= c1_reg;
            res_reg <= c2_reg.ring ? ((dd_reg >> 14) + {14'd0, c2_reg.tzz, 16'd0})
                                   : c2_reg.val;
        end
    end

    assign out_valid = v3_reg;
    assign result    = res_reg;
endmodule
`default_nettype wire

/* src/cutter_implicit_distance.sv */
// Throughput: one point per cycle; the whole pipeline advances together and
// holds when the result register is full and m_tready is low.
// The depth is set by the square root unit, sixteen stages of two root bits.
// Reset: synchronous, active low aresetn; empties the pipeline and returns the
// registers to flat end, radius 1.0, ring 1.0, tube 85/256, length 1.0, tip 0.
`default_nettype none
module cutter_implicit_distance #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input points
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // point_x [15:0], point_y [31:16], point_z [47:32]
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // distance_value [63:0]
    // register writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    localparam int          SH      = 16 - COORD_WIDTH;
    localparam logic [14:0] SZ_MASK = 15'((32'd1 << (COORD_WIDTH - 1)) - 32'd1);

    function automatic logic signed [15:0] sext_c(input logic [15:0] v);
        logic [15:0] t;
        t = v << SH;
        return $signed(t) >>> SH;
    endfunction

    // configuration registers
    logic [1:0]  shape_reg;
    logic [14:0] radius_reg, major_reg, minor_reg, length_reg;
    logic [15:0] pos_x_reg, pos_y_reg, pos_z_reg;
    // derived constants, refreshed every cycle
    logic [29:0] rr_reg, r1sq_reg, r2sq_reg;
    logic [31:0] r12sq_reg;
    logic [14:0] rad_m, maj_m, min_m, len_m;
    logic [15:0] r12_m;

    cid_pkg::cid_cfg_t cfg;

    logic        ce;
    logic        f_valid, b_valid, q_valid;
    cid_pkg::cid_geom_t  geom;
    cid_pkg::cid_carry_t b_carry, q_carry;
    logic [33:0] b_s;
    logic [31:0] q_root;
    logic [4:0]  inflight_reg, inflight_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shape_reg  <= cid_pkg::SHAPE_FLAT;
            radius_reg <= 15'd256;
            major_reg  <= 15'd256;
            minor_reg  <= 15'd85;
            length_reg <= 15'd256;
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            pos_z_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                cid_pkg::REG_SHAPE:  shape_reg  <= cfg_data[1:0];
                cid_pkg::REG_RADIUS: radius_reg <= cfg_data[14:0];
                cid_pkg::REG_MAJOR:  major_reg  <= cfg_data[14:0];
                cid_pkg::REG_MINOR:  minor_reg  <= cfg_data[14:0];
                cid_pkg::REG_LENGTH: length_reg <= cfg_data[14:0];
                cid_pkg::REG_POS_X:  pos_x_reg  <= cfg_data;
                cid_pkg::REG_POS_Y:  pos_y_reg  <= cfg_data;
                cid_pkg::REG_POS_Z:  pos_z_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign rad_m = radius_reg & SZ_MASK;
    assign maj_m = major_reg & SZ_MASK;
    assign min_m = minor_reg & SZ_MASK;
    assign len_m = length_reg & SZ_MASK;
    assign r12_m = {1'b0, maj_m} + {1'b0, min_m};

    always_ff @(posedge aclk) begin
        rr_reg    <= rad_m * rad_m;
        r1sq_reg  <= maj_m * maj_m;
        r2sq_reg  <= min_m * min_m;
        r12sq_reg <= r12_m * r12_m;
    end

    always_comb begin
        cfg.shape  = shape_reg;
        cfg.radius = rad_m;
        cfg.length = len_m;
        case (shape_reg)
            cid_pkg::SHAPE_BALL: cfg.tz_off = rad_m;
            cid_pkg::SHAPE_BULL: cfg.tz_off = min_m;
            default:             cfg.tz_off = '0;
        endcase
        cfg.pos_x = sext_c(pos_x_reg);
        cfg.pos_y = sext_c(pos_y_reg);
        cfg.pos_z = sext_c(pos_z_reg);
        cfg.rr    = rr_reg;
        cfg.r1sq  = r1sq_reg;
        cfg.r2sq  = r2sq_reg;
        cfg.r12sq = r12sq_reg;
        cfg.kq    = {r1sq_reg, 2'b00};
    end

    // single pipeline enable: move on unless the result beat is stuck
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    cid_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_tvalid),
        .px        (sext_c(s_tdata[15:0])),
        .py        (sext_c(s_tdata[31:16])),
        .pz        (sext_c(s_tdata[47:32])),
        .cfg       (cfg),
        .out_valid (f_valid),
        .geom      (geom)
    );

    cid_branch u_branch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (f_valid),
        .geom      (geom),
        .cfg       (cfg),
        .out_valid (b_valid),
        .out_s     (b_s),
        .carry     (b_carry)
    );

    cid_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (b_valid),
        .s         (b_s),
        .in_carry  (b_carry),
        .out_valid (q_valid),
        .root      (q_root),
        .out_carry (q_carry)
    );

    cid_ring u_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (q_valid),
        .root      (q_root),
        .in_carry  (q_carry),
        .radius    (cfg.radius),
        .out_valid (m_tvalid),
        .result    (m_tdata)
    );

    // beats in flight, for checking only
    always_comb begin
        inflight_next = inflight_reg;
        if (s_tvalid && s_tready) begin
            inflight_next = inflight_next + 5'd1;
        end
        if (m_tvalid && m_tready) begin
            inflight_next = inflight_next - 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    a_out_has_source: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> inflight_reg != 5'd0)
        else $error("result beat with nothing in flight");

    a_inflight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= 5'(cid_pkg::LATENCY))
        else $error("more beats in flight than pipeline stages");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && inflight_reg == 5'd0)
        else $error("pipeline not empty after reset");

endmodule
`default_nettype wire
